// ===== src/pla_pkg.sv =====
// Package for the piecewise-linear activation block.
// Holds the per-channel threshold and slope tables, fixed widths and defaults.
// No dependencies.
package pla_pkg;

  localparam int unsigned CH_W          = 2;
  localparam int unsigned THR_W         = 16;
  localparam int unsigned SLOPE_W       = 16;
  localparam int unsigned FRAC_SHIFT    = 14;
  localparam int unsigned TBL_ROWS      = 3;
  localparam int unsigned TBL_COLS      = 16;

  localparam int unsigned DEF_NUM_SEGMENTS = 16;
  localparam int unsigned DEF_NUM_CHANNELS = 3;
  localparam int unsigned DEF_SAMPLE_WIDTH = 16;

  localparam logic signed [THR_W-1:0] THR_ROM [TBL_ROWS][TBL_COLS] = '{
    '{ -16'sd103,  16'sd109,  16'sd227,  16'sd602,  16'sd637,  16'sd680, 16'sd1046, 16'sd1587,
       16'sd2034, 16'sd2360, 16'sd2595, 16'sd2771, 16'sd2940, 16'sd3064, 16'sd3051, 16'sd2849 },
    '{ -16'sd99,   16'sd204,  16'sd276,  16'sd424,  16'sd644, 16'sd1197, 16'sd1474, 16'sd1694,
       16'sd1941, 16'sd2241, 16'sd2440, 16'sd2415, 16'sd2883, 16'sd3083, 16'sd2927, 16'sd3457 },
    '{ -16'sd97,   16'sd169,  16'sd270,  16'sd347,  16'sd413,  16'sd530,  16'sd708,  16'sd932,
       16'sd1400, 16'sd1645, 16'sd1116, 16'sd1993, 16'sd2469, 16'sd2304, 16'sd2551, 16'sd3700 }
  };

  localparam logic signed [SLOPE_W-1:0] SLOPE_ROM [TBL_ROWS][TBL_COLS] = '{
    '{ 16'sd16926,  16'sd562,   16'sd562,   16'sd496,   16'sd447,   16'sd325,
       16'sd204,    16'sd101,  -16'sd11,   -16'sd110,  -16'sd204,  -16'sd308,
      -16'sd445,   -16'sd699,  -16'sd1205, -16'sd3428 },
    '{ 16'sd16138, -16'sd327,  -16'sd321,  -16'sd263,  -16'sd235,  -16'sd169,
      -16'sd171,   -16'sd189,  -16'sd203,  -16'sd235,  -16'sd285,  -16'sd350,
      -16'sd400,   -16'sd726,  -16'sd2034, -16'sd3802 },
    '{ 16'sd15857, -16'sd650,  -16'sd663,  -16'sd652,  -16'sd643,  -16'sd585,
      -16'sd498,   -16'sd428,  -16'sd337,  -16'sd338,  -16'sd543,  -16'sd422,
      -16'sd420,   -16'sd860,  -16'sd1304, -16'sd1224 }
  };

  function automatic logic signed [THR_W-1:0] pla_thr(input logic [CH_W-1:0] ch,
                                                       input int unsigned seg);
    logic signed [THR_W-1:0] val;
    val = '0;
    if (int'(ch) < int'(TBL_ROWS) && seg < TBL_COLS) begin
      val = THR_ROM[int'(ch)][seg];
    end
    return val;
  endfunction

  function automatic logic signed [SLOPE_W-1:0] pla_slope(input logic [CH_W-1:0] ch,
                                                          input int unsigned seg);
    logic signed [SLOPE_W-1:0] val;
    val = '0;
    if (int'(ch) < int'(TBL_ROWS) && seg < TBL_COLS) begin
      val = SLOPE_ROM[int'(ch)][seg];
    end
    return val;
  endfunction

endpackage

// ===== src/piecewise_linear_activation_top.sv =====
// Piecewise-linear activation: input transaction is a channel and a Q3.12
// sample; output transaction is the Q3.12 hinge sum and a saturation flag.
//
// Both channels use valid/ready; a transaction moves when both are high.
// Structure: a row of NUM_SEGMENTS hinge cells, one per segment. Each cell
// looks up its threshold and slope for the item's channel, adds its term to
// the running sum and passes the item on. A final stage rounds, saturates
// and holds the result.
// Each hinge cell registers the item in turn, and the output stage registers
// the rounded, saturated result.
// Throughput: one transaction per cycle while out_ready_i is high, set by
// one multiply-add per cell. Every cell has its own valid flag, so the row
// keeps accepting items while a result waits, until every cell holds an item.
// Stall: while out_ready_i is low, the result holds, items pile up in the
// row, and in_ready_o drops only when the whole row is full.
// Reset: rst_ni clears all valid flags; items in flight are dropped.
// A channel of NUM_CHANNELS or more gives result 0 and saturated 0.
// Depends on pla_pkg, pla_cell and pla_out.
module piecewise_linear_activation_top
  import pla_pkg::*;
#(
  parameter int unsigned NUM_SEGMENTS = DEF_NUM_SEGMENTS,
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [CH_W-1:0]                channel_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] result_o,
  output logic                           saturated_o
);

  localparam int unsigned DIFF_W = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 1;
  localparam int unsigned ACC_W  = DIFF_W + SLOPE_W + $clog2(NUM_SEGMENTS) + 1;

  logic                           valid [NUM_SEGMENTS+1];
  logic                           ready [NUM_SEGMENTS+1];
  logic [CH_W-1:0]                chan  [NUM_SEGMENTS+1];
  logic signed [SAMPLE_WIDTH-1:0] smp   [NUM_SEGMENTS+1];
  logic signed [ACC_W-1:0]        acc   [NUM_SEGMENTS+1];

  assign valid[0]   = in_valid_i;
  assign in_ready_o = ready[0];
  assign chan[0]    = channel_i;
  assign smp[0]     = sample_i;
  assign acc[0]     = '0;

  for (genvar g = 0; g < NUM_SEGMENTS; g++) begin : g_cell
    pla_cell #(
      .SEG_IDX      (g),
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACC_W        (ACC_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid[g]),
      .ready_o  (ready[g]),
      .chan_i   (chan[g]),
      .sample_i (smp[g]),
      .acc_i    (acc[g]),
      .valid_o  (valid[g+1]),
      .ready_i  (ready[g+1]),
      .chan_o   (chan[g+1]),
      .sample_o (smp[g+1]),
      .acc_o    (acc[g+1])
    );
  end

  pla_out #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_W        (ACC_W)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid[NUM_SEGMENTS]),
    .ready_o     (ready[NUM_SEGMENTS]),
    .acc_i       (acc[NUM_SEGMENTS]),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .result_o    (result_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== src/pla_cell.sv =====
// One hinge cell: adds (sample - threshold) * slope for its segment when the
// sample lies above the threshold, then hands the item to the next cell.
// Depends on pla_pkg.
module pla_cell
  import pla_pkg::*;
#(
  parameter int unsigned SEG_IDX      = 0,
  parameter int unsigned NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int unsigned ACC_W        = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [CH_W-1:0]                chan_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [ACC_W-1:0]        acc_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [CH_W-1:0]                chan_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic signed [ACC_W-1:0]        acc_o
);

  localparam int unsigned DIFF_W = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 1;
  localparam int unsigned PROD_W = DIFF_W + SLOPE_W;

  logic signed [DIFF_W-1:0]       x_ext, t_ext, diff;
  logic signed [SLOPE_W-1:0]      slope;
  logic signed [PROD_W-1:0]       prod;
  logic                           chan_ok, hit, load;
  logic                           valid_q;
  logic [CH_W-1:0]                chan_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [ACC_W-1:0]        acc_d, acc_q;

  assign chan_ok = 32'(chan_i) < NUM_CHANNELS;
  assign x_ext   = DIFF_W'(sample_i);
  assign t_ext   = DIFF_W'(pla_thr(chan_i, SEG_IDX));
  assign slope   = pla_slope(chan_i, SEG_IDX);
  assign diff    = x_ext - t_ext;
  assign hit     = chan_ok && (x_ext > t_ext);
  assign prod    = PROD_W'(diff) * PROD_W'(slope);
  assign acc_d   = hit ? acc_i + ACC_W'(prod) : acc_i;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chan_q   <= chan_i;
      sample_q <= sample_i;
      acc_q    <= acc_d;
    end
  end

  assign valid_o  = valid_q;
  assign chan_o   = chan_q;
  assign sample_o = sample_q;
  assign acc_o    = acc_q;

endmodule

// ===== src/pla_out.sv =====
// Output stage: rounds the full-precision sum to Q3.12, saturates it to the
// sample width and holds the result transaction. Depends on pla_pkg.
module pla_out
  import pla_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int unsigned ACC_W        = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [ACC_W-1:0]        acc_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] result_o,
  output logic                           saturated_o
);

  localparam int unsigned Q_W = ACC_W - FRAC_SHIFT;

  logic signed [ACC_W-1:0]        biased;
  logic signed [Q_W-1:0]          q, hi, lo;
  logic signed [SAMPLE_WIDTH-1:0] res_d, res_q;
  logic                           sat_d, sat_q, valid_q, load;

  assign biased = acc_i + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
  assign q      = Q_W'(biased >>> FRAC_SHIFT);
  assign hi     = Q_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  assign lo     = -hi - Q_W'(1);

  always_comb begin
    res_d = SAMPLE_WIDTH'(q);
    sat_d = 1'b0;
    if (q > hi) begin
      res_d = SAMPLE_WIDTH'(hi);
      sat_d = 1'b1;
    end else if (q < lo) begin
      res_d = SAMPLE_WIDTH'(lo);
      sat_d = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o     = valid_q;
  assign result_o    = res_q;
  assign saturated_o = sat_q;

endmodule

// ===== src/pla_checker.sv =====
// Port-level checker for the piecewise-linear activation top level, with the
// bind that attaches it. Depends on pla_pkg and piecewise_linear_activation_top.
module pla_checker
  import pla_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] result_o,
  input logic                           saturated_o
);

  localparam logic signed [SAMPLE_WIDTH-1:0] RES_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] RES_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o) && $stable(saturated_o))
    else $error("stalled result transaction changed");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> result_o == RES_MAX || result_o == RES_MIN)
    else $error("saturated result not at a range limit");

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side not stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind piecewise_linear_activation_top pla_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o),
  .saturated_o (saturated_o)
);
